[rtl/arbd_pkg.sv]
// Package for the alarm relay blink driver.
// Holds the shared widths, the register map codes and the configuration struct.
// No dependencies.
package arbd_pkg;

   localparam int CHAN_W      = 4;
   localparam int HALF_W      = 16;
   localparam int DUR_W       = HALF_W + 1;
   localparam int ELAPSED_W   = 18;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;

   localparam logic [HALF_W-1:0]    HALF_PERIOD_RESET = 16'd500;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX       = {ELAPSED_W{1'b1}};

   // Register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_HALF_PERIOD   = 2'd0,
      REG_ASYNC_MODE    = 2'd1,
      REG_BLINK_MASK    = 2'd2,
      REG_POLARITY_MASK = 2'd3
   } arbd_reg_type;

   typedef struct packed {
      logic [HALF_W-1:0] half_period;
      logic              async_mode;
      logic [CHAN_W-1:0] blink_mask;
      logic [CHAN_W-1:0] polarity_mask;
   } arbd_cfg_type;

endpackage

[rtl/arbd_csr.sv]
// Configuration registers of the alarm relay blink driver, APB-style access.
// Depends on arbd_pkg.
module arbd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [arbd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [arbd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [arbd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output arbd_pkg::arbd_cfg_type               cfg
);

   arbd_pkg::arbd_cfg_type cfg_ff, cfg_in;
   arbd_pkg::arbd_reg_type reg_sel;
   logic                   wr_en;

   assign reg_sel    = arbd_pkg::arbd_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            arbd_pkg::REG_HALF_PERIOD:   cfg_in.half_period   = csr_pwdata[arbd_pkg::HALF_W-1:0];
            arbd_pkg::REG_ASYNC_MODE:    cfg_in.async_mode    = csr_pwdata[0];
            arbd_pkg::REG_BLINK_MASK:    cfg_in.blink_mask    = csr_pwdata[arbd_pkg::CHAN_W-1:0];
            arbd_pkg::REG_POLARITY_MASK: cfg_in.polarity_mask = csr_pwdata[arbd_pkg::CHAN_W-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period   <= arbd_pkg::HALF_PERIOD_RESET;
         cfg_ff.async_mode    <= 1'b0;
         cfg_ff.blink_mask    <= '0;
         cfg_ff.polarity_mask <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         arbd_pkg::REG_HALF_PERIOD:
            csr_prdata[arbd_pkg::HALF_W-1:0] = cfg_ff.half_period;
         arbd_pkg::REG_ASYNC_MODE:
            csr_prdata[0] = cfg_ff.async_mode;
         arbd_pkg::REG_BLINK_MASK:
            csr_prdata[arbd_pkg::CHAN_W-1:0] = cfg_ff.blink_mask;
         arbd_pkg::REG_POLARITY_MASK:
            csr_prdata[arbd_pkg::CHAN_W-1:0] = cfg_ff.polarity_mask;
         default:
            csr_prdata = '0;
      endcase
   end

endmodule

[rtl/arbd_core.sv]
// Blink state, per-tick pin computation and result register.
// Depends on arbd_pkg.
module arbd_core (
   input  logic                               clock,
   input  logic                               reset,
   input  arbd_pkg::arbd_cfg_type             cfg,
   input  logic                               advance,
   input  logic                               item_valid,
   input  logic [arbd_pkg::CHAN_W-1:0]        item_levels,
   output logic                               rsp_valid,
   output logic [arbd_pkg::CHAN_W-1:0]        pin_levels,
   output logic [arbd_pkg::CHAN_W-1:0]        changed_mask,
   output logic                               blink_phase
);

   logic [arbd_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                           phase_ff, phase_in;
   logic [arbd_pkg::CHAN_W-1:0]    prev_ff;
   logic                           valid_ff;
   logic [arbd_pkg::CHAN_W-1:0]    pins_ff, pins_in;
   logic [arbd_pkg::CHAN_W-1:0]    changed_ff, changed_in;
   logic                           phase_out_ff;

   logic [arbd_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic [arbd_pkg::DUR_W-1:0]     duration;
   logic [arbd_pkg::CHAN_W-1:0]    phase_all;
   logic [arbd_pkg::CHAN_W-1:0]    val;
   logic                           take;

   assign take = advance & item_valid;

   // Phase duration doubles for the on phase in async mode
   assign duration = (cfg.async_mode && phase_ff) ? {cfg.half_period, 1'b0}
                                                  : {1'b0, cfg.half_period};

   // Saturating tick counter
   assign elapsed_inc = (elapsed_ff == arbd_pkg::ELAPSED_MAX) ? elapsed_ff
                                                              : elapsed_ff + 1'b1;

   assign changed_in = item_levels ^ prev_ff;

   // Next phase and counter; a level change wins over the counter
   always_comb begin
      priority if (changed_in != '0) begin
         phase_in   = 1'b1;
         elapsed_in = '0;
      end else if (elapsed_inc > arbd_pkg::ELAPSED_W'(duration)) begin
         phase_in   = ~phase_ff;
         elapsed_in = '0;
      end else begin
         phase_in   = phase_ff;
         elapsed_in = elapsed_inc;
      end
   end

   // Blink gating, then polarity (1 passes, 0 inverts)
   assign phase_all = {arbd_pkg::CHAN_W{phase_in}};
   assign val       = (item_levels & ~cfg.blink_mask)
                    | (item_levels & cfg.blink_mask & phase_all);
   assign pins_in   = ~(val ^ cfg.polarity_mask);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         phase_ff   <= 1'b0;
         prev_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= item_valid;
         end
         if (take) begin
            elapsed_ff <= elapsed_in;
            phase_ff   <= phase_in;
            prev_ff    <= item_levels;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take) begin
         pins_ff      <= pins_in;
         changed_ff   <= changed_in;
         phase_out_ff <= phase_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign pin_levels   = pins_ff;
   assign changed_mask = changed_ff;
   assign blink_phase  = phase_out_ff;

endmodule

[rtl/alarm_relay_blink_driver.sv]
// Alarm relay blink driver: four alarm pins with a shared blink phase and per-pin polarity.
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle; the input and result registers advance together
// whenever the result register is empty or being taken.
// Reset (synchronous): counter, phase and previous levels cleared, half period 500,
// async mode and masks zero, both channels empty. Depends on arbd_pkg, arbd_csr, arbd_core.
module alarm_relay_blink_driver (
   input  logic                                 clock,
   input  logic                                 reset,
   // Item input
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [arbd_pkg::REQ_DATA_W-1:0]      req_tdata,   // [3:0] channel_levels
   // Result output
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [arbd_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [3:0] pin_levels,
                                                             // [7:4] changed_mask,
                                                             // [8] blink_phase
   // Configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [arbd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [arbd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [arbd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   arbd_pkg::arbd_cfg_type         cfg;
   logic                           in_valid_ff, in_valid_in;
   logic [arbd_pkg::CHAN_W-1:0]    in_levels_ff;
   logic                           advance;
   logic                           accept;
   logic [arbd_pkg::CHAN_W-1:0]    pin_levels;
   logic [arbd_pkg::CHAN_W-1:0]    changed_mask;
   logic                           blink_phase;

   arbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pipeline moves when the result register is free or being taken
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   // Input register
   always_comb begin
      priority if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_levels_ff <= req_tdata[arbd_pkg::CHAN_W-1:0];
      end
   end

   arbd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .advance      (advance),
      .item_valid   (in_valid_ff),
      .item_levels  (in_levels_ff),
      .rsp_valid    (rsp_tvalid),
      .pin_levels   (pin_levels),
      .changed_mask (changed_mask),
      .blink_phase  (blink_phase)
   );

   assign rsp_tdata = {7'd0, blink_phase, changed_mask, pin_levels};

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the alarm relay blink driver: drives tick items on
// the req_ stream, checks every rsp_ item and programs the csr_ port.
// Depends on arbd_pkg and the alarm_relay_blink_driver RTL.
`timescale 1ns / 1ps

module tb_top;

   // One expected response item
   typedef struct packed {
      logic [arbd_pkg::CHAN_W-1:0] pins;
      logic [arbd_pkg::CHAN_W-1:0] changed;
      logic                        phase;
   } pin_result_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [arbd_pkg::REQ_DATA_W-1:0] req_tdata;   // [3:0] channel_levels
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // [3:0] pin_levels, [7:4] changed_mask, [8] blink_phase
   logic [arbd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [arbd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [arbd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [arbd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Shadow registers and blink state of the model
   logic [arbd_pkg::HALF_W-1:0]    half_shadow;
   logic                           async_shadow;
   logic [arbd_pkg::CHAN_W-1:0]    blink_shadow;
   logic [arbd_pkg::CHAN_W-1:0]    polarity_shadow;
   logic [arbd_pkg::ELAPSED_W-1:0] tick_count;
   logic                           phase_on;
   logic [arbd_pkg::CHAN_W-1:0]    last_levels;

   pin_result_type pending_pins[$];
   logic [arbd_pkg::CHAN_W-1:0] stream_levels;

   int  fail_count;
   int  items_sent;
   int  results_seen;
   int  csr_writes;
   bit  src_idle_on;
   bit  sink_idle_on;
   int  sink_hold_cycles;

   alarm_relay_blink_driver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Advance the blink model by one tick and give the expected response
   function automatic pin_result_type predict_alarm_pins(
      input logic [arbd_pkg::CHAN_W-1:0] levels);
      pin_result_type              res;
      logic [arbd_pkg::DUR_W-1:0]  duration;
      logic [arbd_pkg::CHAN_W-1:0] follow;
      res.changed = levels ^ last_levels;
      if (res.changed != '0) begin
         phase_on   = 1'b1;
         tick_count = '0;
      end else begin
         if (tick_count != arbd_pkg::ELAPSED_MAX)
            tick_count = tick_count + 1'b1;
         duration = (async_shadow && phase_on) ? {half_shadow, 1'b0} : {1'b0, half_shadow};
         if (tick_count > duration) begin
            phase_on   = ~phase_on;
            tick_count = '0;
         end
      end
      // blinking asserted channels follow the phase, then polarity
      follow      = (levels & ~blink_shadow)
                  | (levels & blink_shadow & {arbd_pkg::CHAN_W{phase_on}});
      res.pins    = ~(follow ^ polarity_shadow);
      res.phase   = phase_on;
      last_levels = levels;
      return res;
   endfunction

   function automatic logic [arbd_pkg::CSR_DATA_W-1:0] shadow_value(
      input arbd_pkg::arbd_reg_type idx);
      case (idx)
         arbd_pkg::REG_HALF_PERIOD: return arbd_pkg::CSR_DATA_W'(half_shadow);
         arbd_pkg::REG_ASYNC_MODE:  return arbd_pkg::CSR_DATA_W'(async_shadow);
         arbd_pkg::REG_BLINK_MASK:  return arbd_pkg::CSR_DATA_W'(blink_shadow);
         default:                   return arbd_pkg::CSR_DATA_W'(polarity_shadow);
      endcase
   endfunction

   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
   endtask

   // Register write: setup then access cycle
   task automatic csr_write(input arbd_pkg::arbd_reg_type idx,
                            input logic [arbd_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         arbd_pkg::REG_HALF_PERIOD: half_shadow     = value[arbd_pkg::HALF_W-1:0];
         arbd_pkg::REG_ASYNC_MODE:  async_shadow    = value[0];
         arbd_pkg::REG_BLINK_MASK:  blink_shadow    = value[arbd_pkg::CHAN_W-1:0];
         default:                   polarity_shadow = value[arbd_pkg::CHAN_W-1:0];
      endcase
      csr_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check(input arbd_pkg::arbd_reg_type idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== shadow_value(idx))
         note_mismatch($sformatf("register %s readback", idx.name()), shadow_value(idx),
                       csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Low bits carry the field, upper bits random to show they are dropped
   task automatic set_blink(input logic [arbd_pkg::HALF_W-1:0] half, input logic async_on,
                            input logic [arbd_pkg::CHAN_W-1:0] blink,
                            input logic [arbd_pkg::CHAN_W-1:0] pol);
      logic [arbd_pkg::CSR_DATA_W-1:0] noise;
      noise = $urandom;
      csr_write(arbd_pkg::REG_HALF_PERIOD,   {noise[31:16], half});
      csr_write(arbd_pkg::REG_ASYNC_MODE,    {noise[31:1], async_on});
      csr_write(arbd_pkg::REG_BLINK_MASK,    {noise[31:4], blink});
      csr_write(arbd_pkg::REG_POLARITY_MASK, {noise[31:4], pol});
   endtask

   // Offer one tick item, sometimes with a random idle burst in front of it
   task automatic send_levels(input logic [arbd_pkg::CHAN_W-1:0] levels);
      int gap;
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= arbd_pkg::REQ_DATA_W'($urandom_range(0, 15));
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= arbd_pkg::REQ_DATA_W'(levels);
      do @(posedge clock); while (!req_tready);
      pending_pins.push_back(predict_alarm_pins(levels));
      items_sent++;
   endtask

   // Stop offering and wait until every response is back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly steady levels so the phase gets to flip, with occasional changes
   function automatic logic [arbd_pkg::CHAN_W-1:0] next_stream_levels(
      input logic [arbd_pkg::CHAN_W-1:0] cur);
      if ($urandom_range(0, 7) == 0)
         return arbd_pkg::CHAN_W'($urandom_range(0, 15));
      return cur;
   endfunction

   // Receiver: random idle bursts plus an optional long hold-off
   initial begin : rsp_sink
      int gap_left;
      bit ready_now;
      gap_left   = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            ready_now = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            ready_now = 1'b0;
         end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            gap_left  = $urandom_range(1, 13) - 1;
            ready_now = 1'b0;
         end else begin
            ready_now = 1'b1;
         end
         rsp_tready <= ready_now;
      end
   end

   // Response checker
   always @(posedge clock) begin : rsp_check
      pin_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_pins.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t response item with nothing expected: 0x%0h", $realtime, rsp_tdata);
         end else begin
            want = pending_pins.pop_front();
            if (rsp_tdata[3:0] !== want.pins)
               note_mismatch("pin_levels", want.pins, rsp_tdata[3:0]);
            if (rsp_tdata[7:4] !== want.changed)
               note_mismatch("changed_mask", want.changed, rsp_tdata[7:4]);
            if (rsp_tdata[8] !== want.phase)
               note_mismatch("blink_phase", want.phase, rsp_tdata[8]);
         end
      end
   end

   // Reset values read back, then a few ticks with inverted pins and no blink
   task automatic test_reset_defaults();
      csr_check(arbd_pkg::REG_HALF_PERIOD);
      csr_check(arbd_pkg::REG_ASYNC_MODE);
      csr_check(arbd_pkg::REG_BLINK_MASK);
      csr_check(arbd_pkg::REG_POLARITY_MASK);
      send_levels(4'h0);
      send_levels(4'h5);
      send_levels(4'hF);
      drain_results();
   endtask

   task automatic test_directed_cases();
      // half period of one, all channels blinking, active high
      set_blink(16'd1, 1'b0, 4'hF, 4'hF);
      csr_check(arbd_pkg::REG_HALF_PERIOD);
      csr_check(arbd_pkg::REG_BLINK_MASK);
      csr_check(arbd_pkg::REG_POLARITY_MASK);
      send_levels(4'hF);
      send_levels(4'hF);
      send_levels(4'hF);
      // each channel alone
      send_levels(4'h1);
      send_levels(4'h2);
      send_levels(4'h4);
      send_levels(4'h8);
      drain_results();
      // async: the on phase lasts twice as long
      csr_write(arbd_pkg::REG_ASYNC_MODE, 32'd1);
      csr_check(arbd_pkg::REG_ASYNC_MODE);
      repeat (4) send_levels(4'h8);
      drain_results();
      // zero half period flips on every steady tick
      csr_write(arbd_pkg::REG_HALF_PERIOD, 32'd0);
      repeat (3) send_levels(4'h6);
      drain_results();
      // half period lowered while the counter is well past the new value
      set_blink(16'd500, 1'b0, 4'h5, 4'hA);
      repeat (5) send_levels(4'h9);
      drain_results();
      csr_write(arbd_pkg::REG_HALF_PERIOD, 32'd2);
      send_levels(4'h9);
      drain_results();
      // longest half period
      csr_write(arbd_pkg::REG_HALF_PERIOD, 32'hFFFF_FFFF);
      csr_check(arbd_pkg::REG_HALF_PERIOD);
      send_levels(4'h9);
      send_levels(4'h9);
      drain_results();
   endtask

   task automatic test_random_settings();
      int                          round;
      logic [arbd_pkg::HALF_W-1:0] half;
      for (round = 0; round < 7; round++) begin
         case ($urandom_range(0, 5))
            0:       half = 16'd1;
            1:       half = 16'hFFFF;
            2:       half = arbd_pkg::HALF_W'($urandom_range(1, 65535));
            default: half = arbd_pkg::HALF_W'($urandom_range(1, 6));
         endcase
         set_blink(half, 1'($urandom_range(0, 1)), arbd_pkg::CHAN_W'($urandom_range(0, 15)),
                   arbd_pkg::CHAN_W'($urandom_range(0, 15)));
         repeat (60) begin
            stream_levels = next_stream_levels(stream_levels);
            send_levels(stream_levels);
         end
         drain_results();
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   task automatic test_output_stall();
      set_blink(16'd3, 1'b1, 4'hC, 4'h3);
      src_idle_on = 1'b0;
      @(posedge clock);
      sink_hold_cycles = 40;
      repeat (20) begin
         stream_levels = next_stream_levels(stream_levels);
         send_levels(stream_levels);
      end
      drain_results();
      src_idle_on = 1'b1;
   endtask

   // Back to back on both sides
   task automatic test_full_rate();
      set_blink(16'd2, 1'b1, 4'hF, 4'h6);
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      repeat (60) begin
         stream_levels = next_stream_levels(stream_levels);
         send_levels(stream_levels);
      end
      drain_results();
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      half_shadow      = arbd_pkg::HALF_PERIOD_RESET;
      async_shadow     = 1'b0;
      blink_shadow     = '0;
      polarity_shadow  = '0;
      tick_count       = '0;
      phase_on         = 1'b0;
      last_levels      = '0;
      stream_levels    = '0;
      fail_count       = 0;
      items_sent       = 0;
      results_seen     = 0;
      csr_writes       = 0;
      src_idle_on      = 1'b1;
      sink_idle_on     = 1'b1;
      sink_hold_cycles = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_random_settings();
      test_output_stall();
      test_full_rate();

      repeat (8) @(posedge clock);
      if (pending_pins.size() != 0) begin
         fail_count++;
         $display("%0d expected response items never arrived", pending_pins.size());
      end
      $display("Sent %0d tick items, checked %0d responses, %0d register writes,",
               items_sent, results_seen, csr_writes);
      $display("across zero, minimum and maximum half periods, async mode and a long stall.");
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
